[hw/rtl/pffla_pkg.sv]
package pffla_pkg;

  localparam int unsigned FRAME_COUNT_DEF = 128;
  localparam int unsigned PAGE_SHIFT_DEF  = 21;
  localparam logic [31:0] BASE_ADDR_RST   = 32'h0010_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] count;
    logic       chain_present;
    logic [6:0] chain_head;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [6:0]  first_frame;
    logic [31:0] first_address;
  } out_t;

endpackage

[hw/rtl/pffla_ram.sv]
module pffla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/page_frame_free_list_allocator_top.sv]
// Page frame allocator over a singly linked free list.
//
// Input channel (in_valid / in_stall / in_data): one request per beat.
// op allocate detaches count frames from the head of the free list;
// op free walks the given chain to its tail and prepends it to the list.
// Result channel (out_valid / out_stall / out_data): one result beat per
// request, with ok, the first frame and its address (base + index shifted
// by the page size, modulo 2^32); zeros for frees and failed requests.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes the base
// address; write it only while no request is in flight.
//
// The links sit in a RAM with one read and one write port and are
// followed one per cycle by a walk sequencer. An allocate walks count
// frames and then emits its result; a free walks the chain to its tail and
// fails on a cyclic chain; a request refused at once goes straight to the
// emit step. in_stall is high from accept until the result is loaded into
// the output register, so a new request can be taken only after that. A
// stalled result stays in the output register while the next request
// walks; its result waits for the register.
// Reset clears the per-frame written flags, so links read as the initial chain.
module page_frame_free_list_allocator_top
  import pffla_pkg::*;
#(
  parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IDX_W  = $clog2(FRAME_COUNT);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam int unsigned STEP_W = $clog2(FRAME_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  typedef enum logic [1:0] {S_IDLE, S_AWALK, S_FWALK, S_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        base_r;
  logic [IDX_W-1:0]   head_idx_r, head_idx_nxt;
  logic               head_ok_r, head_ok_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic [7:0]         count_r, count_nxt;
  logic [7:0]         n_r, n_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic [FRAME_COUNT-1:0] written_r;
  // op of the request in flight is kept in a flag
  logic               op_free_r;

  logic               in_acc;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [LINK_W-1:0]  ram_rdata;
  logic               link_ok;
  logic [IDX_W-1:0]   link_idx;
  logic [IDX_W-1:0]   chain_idx;
  logic               chain_in_range;
  logic [31:0]        addr_sum;

  pffla_ram #(
    .WIDTH(LINK_W),
    .DEPTH(FRAME_COUNT)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // unwritten entries read as the initial chain
  always_comb begin
    if (written_r[cur_r]) begin
      link_ok  = ram_rdata[IDX_W];
      link_idx = ram_rdata[IDX_W-1:0];
    end else begin
      link_ok  = (cur_r != LAST_IDX);
      link_idx = (cur_r == LAST_IDX) ? '0 : cur_r + 1'b1;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign chain_idx      = IDX_W'(in_data.chain_head);
  assign chain_in_range = ({25'd0, in_data.chain_head} < 32'(FRAME_COUNT));
  assign addr_sum       = base_r + (32'(start_r) << PAGE_SHIFT);

  always_comb begin
    state_nxt     = state_r;
    head_idx_nxt  = head_idx_r;
    head_ok_nxt   = head_ok_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    steps_nxt     = steps_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_raddr     = cur_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          count_nxt  = in_data.count;
          res_ok_nxt = 1'b0;
          if (in_data.op == OP_ALLOC) begin
            cur_nxt   = head_idx_r;
            start_nxt = head_idx_r;
            n_nxt     = 8'd1;
            ram_raddr = head_idx_r;
            if (in_data.count != 8'd0 && head_ok_r) begin
              state_nxt = S_AWALK;
            end else begin
              state_nxt = S_EMIT;
            end
          end else begin
            cur_nxt   = chain_idx;
            start_nxt = chain_idx;
            steps_nxt = '0;
            ram_raddr = chain_idx;
            if (in_data.chain_present && chain_in_range) begin
              state_nxt = S_FWALK;
            end else begin
              state_nxt = S_EMIT;
            end
          end
        end
      end
      S_AWALK: begin
        if (n_r < count_r) begin
          if (!link_ok) begin
            state_nxt = S_EMIT;
          end else begin
            cur_nxt   = link_idx;
            ram_raddr = link_idx;
            n_nxt     = n_r + 8'd1;
          end
        end else begin
          // cur is the last frame handed out: its link becomes the head
          head_idx_nxt = link_idx;
          head_ok_nxt  = link_ok;
          ram_we       = 1'b1;
          ram_wdata    = '0;
          res_ok_nxt   = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_FWALK: begin
        if (link_ok && steps_r < STEP_W'(FRAME_COUNT)) begin
          cur_nxt   = link_idx;
          ram_raddr = link_idx;
          steps_nxt = steps_r + 1'b1;
        end else begin
          if (!link_ok) begin
            ram_we       = 1'b1;
            ram_wdata    = {head_ok_r, head_idx_r};
            head_idx_nxt = start_r;
            head_ok_nxt  = 1'b1;
            res_ok_nxt   = 1'b1;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.ok = res_ok_r;
          // frees report no frame
          if (res_ok_r && !op_free_r) begin
            out_data_nxt.first_frame   = 7'(start_r);
            out_data_nxt.first_address = addr_sum;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= BASE_ADDR_RST;
      head_idx_r  <= '0;
      head_ok_r   <= 1'b1;
      out_valid_r <= 1'b0;
      written_r   <= '0;
      res_ok_r    <= 1'b0;
      op_free_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_idx_r  <= head_idx_nxt;
      head_ok_r   <= head_ok_nxt;
      out_valid_r <= out_valid_nxt;
      res_ok_r    <= res_ok_nxt;
      if (in_acc) begin
        op_free_r <= (in_data.op == OP_FREE);
      end
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
      if (ram_we) begin
        written_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    start_r    <= start_nxt;
    count_r    <= count_nxt;
    n_r        <= n_nxt;
    steps_r    <= steps_nxt;
    out_data_r <= out_data_nxt;
  end

  a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result appeared without an emit step");

  a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_AWALK || state_r == S_FWALK))
    else $error("link write outside a walk");

  a_free_sets_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWALK && ram_we) |=> (head_ok_r && head_idx_r == $past(start_r)))
    else $error("freed chain not at the head of the list");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.ok || out_data_r.first_address == 32'd0))
    else $error("failed result carries an address");

  a_held_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AWALK || state_r == S_FWALK) |=> (state_r != S_IDLE))
    else $error("walk ended without an emit step");

endmodule
